@@ rtl/fdc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, codes and helpers for the floppy disk controller.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Disk geometry
    localparam int SECTOR_BYTES      = 137;
    localparam int SECTORS_PER_TRACK = 32;
    localparam int TRACK_COUNT       = 77;
    localparam int DRIVE_COUNT       = 16;

    localparam int ADDR_W = 19;

    // Action codes of an input transaction
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_SELECT      = 3'd1;
    localparam logic [2:0] ACT_STATUS_RD   = 3'd2;
    localparam logic [2:0] ACT_CONTROL     = 3'd3;
    localparam logic [2:0] ACT_SECTOR_RD   = 3'd4;
    localparam logic [2:0] ACT_DATA_WR     = 3'd5;
    localparam logic [2:0] ACT_DATA_RD     = 3'd6;

    // Memory request codes
    localparam logic [1:0] MREQ_NONE  = 2'd0;
    localparam logic [1:0] MREQ_READ  = 2'd1;
    localparam logic [1:0] MREQ_WRITE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_DRIVE_MASK   = 2'd0;
    localparam logic [1:0] CFG_STEP_TICKS   = 2'd1;
    localparam logic [1:0] CFG_LOAD_TICKS   = 2'd2;
    localparam logic [1:0] CFG_SECTOR_TICKS = 2'd3;

    // Status bit positions (active low)
    localparam int ST_ENWD   = 0;
    localparam int ST_MOVEHD = 1;
    localparam int ST_STATHD = 2;
    localparam int ST_INTE   = 5;
    localparam int ST_TRACK0 = 6;
    localparam int ST_NRDA   = 7;

    localparam logic [7:0] STATUS_IDLE     = 8'hff;
    localparam logic [7:0] STATUS_SELECTED = 8'ha5;
    localparam logic [7:0] BYTE_BLANK      = 8'hff;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] data_byte;
        logic       cpu_int_enabled;
    } t_in_item;

    typedef struct packed {
        logic [7:0]        read_data;
        logic [1:0]        mem_request;
        logic [3:0]        mem_drive;
        logic [ADDR_W-1:0] mem_address;
        logic [7:0]        mem_write_data;
    } t_out_item;

    typedef struct packed {
        logic [15:0] drive_present_mask;
        logic [7:0]  step_ticks;
        logic [7:0]  load_ticks;
        logic [7:0]  sector_ticks;
    } t_cfg;

    // Drive is usable when in range and its image is mounted
    function automatic logic drive_ok(input logic [15:0] mask, input logic [3:0] drv);
        return (32'(drv) < DRIVE_COUNT) && mask[drv];
    endfunction

    // Byte offset of (track, sector, byte) in a disk image, modulo the address width
    function automatic logic [ADDR_W-1:0] image_addr(input logic [6:0] trk,
                                                     input logic [4:0] sec,
                                                     input logic [7:0] byte_idx);
        logic [ADDR_W-1:0] idx;
        idx = ADDR_W'(trk) * ADDR_W'(SECTORS_PER_TRACK) + ADDR_W'(sec);
        return idx * ADDR_W'(SECTOR_BYTES) + ADDR_W'(byte_idx);
    endfunction

endpackage

@@ rtl/fdc_engine.sv @@
// ----------------------------------------------------------------------------
// fdc_engine
// Controller state and the one-pass update for a single transaction.
// ----------------------------------------------------------------------------
module fdc_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  fdc_pkg::t_in_item i_item,
    input  fdc_pkg::t_cfg     i_cfg,
    output fdc_pkg::t_out_item o_result
);
    import fdc_pkg::*;

    logic [6:0] r_drive_track [DRIVE_COUNT];
    logic [6:0] n_drive_track [DRIVE_COUNT];
    logic [4:0] r_sector_pos,      n_sector_pos;
    logic [4:0] r_rw_sector,       n_rw_sector;
    logic [3:0] r_sel_drive,       n_sel_drive;
    logic [7:0] r_status,          n_status;
    logic       r_enabled,         n_enabled;
    logic       r_head_loaded,     n_head_loaded;
    logic       r_write_active,    n_write_active;
    logic [7:0] r_byte_cnt,        n_byte_cnt;
    logic [7:0] r_sector_tick_cnt, n_sector_tick_cnt;
    logic [7:0] r_head_timer,      n_head_timer;
    logic [7:0] r_step_timer,      n_step_timer;
    logic       r_read_blank,      n_read_blank;
    logic [6:0] r_read_track,      n_read_track;

    logic [3:0] drv;
    logic       drv_present;
    logic       do_disable;
    logic       same_sector;
    logic [6:0] trk;
    logic [8:0] tick_cnt_inc;
    logic [7:0] trk_inc;
    t_out_item  res;

    assign drv         = r_sel_drive;
    assign drv_present = drive_ok(i_cfg.drive_present_mask, drv);

    // Work out the next state and the result of the current transaction
    always_comb begin
        n_drive_track     = r_drive_track;
        n_sector_pos      = r_sector_pos;
        n_rw_sector       = r_rw_sector;
        n_sel_drive       = r_sel_drive;
        n_status          = r_status;
        n_enabled         = r_enabled;
        n_head_loaded     = r_head_loaded;
        n_write_active    = r_write_active;
        n_byte_cnt        = r_byte_cnt;
        n_sector_tick_cnt = r_sector_tick_cnt;
        n_head_timer      = r_head_timer;
        n_step_timer      = r_step_timer;
        n_read_blank      = r_read_blank;
        n_read_track      = r_read_track;
        do_disable        = 1'b0;
        same_sector       = 1'b1;
        trk               = r_drive_track[drv];
        tick_cnt_inc      = {1'b0, r_sector_tick_cnt} + 9'd1;
        trk_inc           = {1'b0, trk} + 8'd1;
        res               = '0;

        case (i_item.action)
            ACT_TICK: begin
                if (r_enabled) begin
                    // Rotate the disk
                    if (tick_cnt_inc > {1'b0, i_cfg.sector_ticks}) begin
                        n_sector_tick_cnt = '0;
                        if (32'(r_sector_pos) >= SECTORS_PER_TRACK - 1) begin
                            n_sector_pos = '0;
                        end else begin
                            n_sector_pos = r_sector_pos + 5'd1;
                        end
                    end else begin
                        n_sector_tick_cnt = tick_cnt_inc[7:0];
                    end
                    // Count down the settle and step timers
                    if (r_head_timer != '0) begin
                        n_head_timer = r_head_timer - 8'd1;
                        if (n_head_timer == '0) n_status[ST_STATHD] = 1'b0;
                    end
                    if (r_step_timer != '0) begin
                        n_step_timer = r_step_timer - 8'd1;
                        if (n_step_timer == '0) n_status[ST_MOVEHD] = 1'b0;
                    end
                end
            end

            ACT_SELECT: begin
                if (i_item.data_byte[7]) begin
                    do_disable = 1'b1;
                end else begin
                    n_sel_drive = i_item.data_byte[3:0];
                    if (!drive_ok(i_cfg.drive_present_mask, i_item.data_byte[3:0])) begin
                        do_disable = 1'b1;
                    end else begin
                        n_enabled      = 1'b1;
                        n_status       = STATUS_SELECTED;
                        n_write_active = 1'b0;
                        n_head_loaded  = 1'b0;
                        n_head_timer   = '0;
                        n_step_timer   = '0;
                    end
                end
            end

            ACT_STATUS_RD: begin
                if (r_enabled) begin
                    n_status[ST_INTE]   = !i_item.cpu_int_enabled;
                    n_status[ST_TRACK0] = (trk != '0);
                end
                res.read_data = n_status;
            end

            ACT_CONTROL: begin
                if (r_enabled) begin
                    // Step in
                    if (i_item.data_byte[0] && (trk_inc < 8'(TRACK_COUNT))) begin
                        trk                  = trk_inc[6:0];
                        n_status[ST_MOVEHD]  = 1'b1;
                        n_step_timer         = i_cfg.step_ticks;
                        if (r_head_loaded) begin
                            n_status[ST_STATHD] = 1'b1;
                            n_head_timer        = i_cfg.load_ticks;
                        end
                    end
                    // Step out
                    if (i_item.data_byte[1] && (trk != '0)) begin
                        trk                  = trk - 7'd1;
                        n_status[ST_MOVEHD]  = 1'b1;
                        n_step_timer         = i_cfg.step_ticks;
                        if (r_head_loaded) begin
                            n_status[ST_STATHD] = 1'b1;
                            n_head_timer        = i_cfg.load_ticks;
                        end
                    end
                    n_drive_track[drv] = trk;
                    // Head load
                    if (i_item.data_byte[2]) begin
                        n_head_loaded       = 1'b1;
                        n_head_timer        = i_cfg.load_ticks;
                        n_status[ST_MOVEHD] = 1'b1;
                        n_step_timer        = i_cfg.load_ticks;
                    end
                    // Head unload
                    if (i_item.data_byte[3]) begin
                        n_head_loaded       = 1'b0;
                        n_head_timer        = '0;
                        n_status[ST_STATHD] = 1'b1;
                    end
                    // Start of a sector write
                    if (i_item.data_byte[7] && !r_write_active) begin
                        n_write_active    = 1'b1;
                        n_byte_cnt        = '0;
                        n_status[ST_ENWD] = 1'b0;
                    end
                end
            end

            ACT_SECTOR_RD: begin
                if (!r_enabled || r_status[ST_STATHD]) begin
                    n_status[ST_NRDA] = 1'b1;
                    n_status[ST_ENWD] = 1'b1;
                    res.read_data     = BYTE_BLANK;
                end else begin
                    if (r_sector_pos != r_rw_sector) begin
                        n_rw_sector       = r_sector_pos;
                        same_sector       = 1'b0;
                        n_status[ST_NRDA] = 1'b0;
                        n_status[ST_ENWD] = 1'b1;
                        n_byte_cnt        = '0;
                    end
                    res.read_data = {2'b00, n_rw_sector, same_sector};
                end
            end

            ACT_DATA_WR: begin
                if (32'(r_byte_cnt) < SECTOR_BYTES) begin
                    if (drv_present) begin
                        res.mem_request    = MREQ_WRITE;
                        res.mem_drive      = drv;
                        res.mem_address    = image_addr(trk, r_rw_sector, r_byte_cnt);
                        res.mem_write_data = i_item.data_byte;
                    end
                    n_byte_cnt = r_byte_cnt + 8'd1;
                    if (32'(n_byte_cnt) == SECTOR_BYTES) begin
                        n_write_active = 1'b0;
                        if (!drv_present) do_disable = 1'b1;
                    end
                end
            end

            ACT_DATA_RD: begin
                // Latch the track and blank flag on the first byte of a sector
                if (r_byte_cnt == '0) begin
                    if (!drv_present) begin
                        do_disable   = 1'b1;
                        n_read_blank = 1'b1;
                    end else begin
                        n_read_blank = 1'b0;
                        n_read_track = trk;
                    end
                end
                if (32'(r_byte_cnt) >= SECTOR_BYTES) begin
                    res.read_data = BYTE_BLANK;
                end else begin
                    if (n_read_blank) begin
                        res.read_data = BYTE_BLANK;
                    end else begin
                        res.mem_request = MREQ_READ;
                        res.mem_drive   = drv;
                        res.mem_address = image_addr(n_read_track, r_rw_sector, r_byte_cnt);
                    end
                    n_byte_cnt = r_byte_cnt + 8'd1;
                    if (32'(n_byte_cnt) == SECTOR_BYTES) n_status[ST_NRDA] = 1'b1;
                end
            end

            default: begin
            end
        endcase

        // Drop the controller to its disabled state
        if (do_disable) begin
            n_enabled      = 1'b0;
            n_status       = STATUS_IDLE;
            n_head_loaded  = 1'b0;
            n_write_active = 1'b0;
            n_head_timer   = '0;
            n_step_timer   = '0;
        end
    end

    assign o_result = res;

    // Commit the new state when the transaction is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DRIVE_COUNT; i++) r_drive_track[i] <= '0;
            r_sector_pos      <= '0;
            r_rw_sector       <= '0;
            r_sel_drive       <= '0;
            r_status          <= STATUS_IDLE;
            r_enabled         <= 1'b0;
            r_head_loaded     <= 1'b0;
            r_write_active    <= 1'b0;
            r_byte_cnt        <= '0;
            r_sector_tick_cnt <= '0;
            r_head_timer      <= '0;
            r_step_timer      <= '0;
            r_read_blank      <= 1'b0;
            r_read_track      <= '0;
        end else if (i_fire) begin
            r_drive_track     <= n_drive_track;
            r_sector_pos      <= n_sector_pos;
            r_rw_sector       <= n_rw_sector;
            r_sel_drive       <= n_sel_drive;
            r_status          <= n_status;
            r_enabled         <= n_enabled;
            r_head_loaded     <= n_head_loaded;
            r_write_active    <= n_write_active;
            r_byte_cnt        <= n_byte_cnt;
            r_sector_tick_cnt <= n_sector_tick_cnt;
            r_head_timer      <= n_head_timer;
            r_step_timer      <= n_step_timer;
            r_read_blank      <= n_read_blank;
            r_read_track      <= n_read_track;
        end
    end

endmodule

@@ rtl/floppy_disk_controller_top.sv @@
// ----------------------------------------------------------------------------
// floppy_disk_controller_top
// An accepted transaction is held in the input register, then registered as
// its result. Throughput: one transaction per cycle unless the output stalls;
// input register, single-pass update and result register overlap across items.
// Reset: synchronous active-low; clears all controller state and loads the
// configuration registers with their defaults.
// ----------------------------------------------------------------------------
module floppy_disk_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fdc_pkg::t_in_item  i_in_data,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fdc_pkg::t_out_item o_out_data,
    // Configuration write port
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import fdc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    t_cfg      r_cfg;
    t_out_item w_result;
    logic      w_out_free;
    logic      w_fire;
    logic      w_accept;

    // Handshake: process the held transaction when the result register frees up
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Hold the accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_in <= i_in_data;
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) r_out <= w_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_present_mask <= 16'hffff;
            r_cfg.step_ticks         <= 8'd10;
            r_cfg.load_ticks         <= 8'd40;
            r_cfg.sector_ticks       <= 8'd5;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRIVE_MASK:   r_cfg.drive_present_mask <= i_cfg_data;
                CFG_STEP_TICKS:   r_cfg.step_ticks         <= i_cfg_data[7:0];
                CFG_LOAD_TICKS:   r_cfg.load_ticks         <= i_cfg_data[7:0];
                CFG_SECTOR_TICKS: r_cfg.sector_ticks       <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fdc_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (r_in),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    // A held transaction is neither lost nor altered while it waits
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in))
        else $error("held input transaction changed before processing");

    // No memory request means no drive, address or write data
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.mem_request == MREQ_NONE) |->
            (o_out_data.mem_drive == '0) && (o_out_data.mem_address == '0) &&
            (o_out_data.mem_write_data == '0))
        else $error("memory fields set without a request");

    // Image reads return no CPU byte from the controller itself
    a_read_req_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.mem_request == MREQ_READ) |->
            (o_out_data.read_data == '0) && (o_out_data.mem_write_data == '0))
        else $error("read request carries data");

    // A result is only loaded into a free result register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the floppy disk controller. A directed table opens
// the run (reset state, disabled-port access, status bits, head load and
// settle, whole and overrun sectors, absent drives). Random phases follow,
// each under new register settings, built mostly from select/load/settle/
// sector-read/data-burst runs with random content plus stray port accesses.
// Each result is checked against a typed table entry or the in-bench model.
// ----------------------------------------------------------------------------
module tb;
    import fdc_pkg::*;

    localparam logic [2:0] ACT_UNUSED     = 3'd7;
    // Control port bits
    localparam logic [7:0] CTL_STEP_IN     = 8'h01;
    localparam logic [7:0] CTL_STEP_OUT    = 8'h02;
    localparam logic [7:0] CTL_HEAD_LOAD   = 8'h04;
    localparam logic [7:0] CTL_HEAD_UNLOAD = 8'h08;
    localparam logic [7:0] CTL_WRITE_EN    = 8'h80;
    // Select port bit that deselects all drives
    localparam logic [7:0] SEL_OFF         = 8'h80;

    localparam t_out_item ZERO_RES = '0;

    localparam int    PHASES        = 5;
    localparam int    PHASE_ITEMS   = 60;
    localparam int    SETTLE_CYCLES = 4;
    localparam int    SETTLE_CAP    = 300;
    localparam int    DIR_ROWS      = 28;
    localparam real   LIMIT_NS      = 2_000_000.0;

    typedef struct packed {
        logic [2:0] act;
        logic [7:0] dat;
        logic       ie;
        logic [7:0] reps;
        logic       typed;
        t_out_item  res;
    } t_dir_row;

    // DUT connections
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;
    logic        i_cfg_we    = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;

    // Controller model state
    t_cfg       cfg_m = '{16'hffff, 8'd10, 8'd40, 8'd5};
    logic [6:0] trk_tab [DRIVE_COUNT] = '{default: '0};
    logic [4:0] sec_pos    = '0;
    logic [4:0] rw_sec     = '0;
    logic [3:0] sel_drv    = '0;
    logic [7:0] sts        = STATUS_IDLE;
    logic       ctl_en     = 1'b0;
    logic       hd_loaded  = 1'b0;
    logic       wr_active  = 1'b0;
    logic       blank_rd   = 1'b0;
    logic [6:0] rd_trk     = '0;
    logic [7:0] byte_cnt   = '0;
    logic [7:0] tick_cnt   = '0;
    logic [7:0] hd_tmr     = '0;
    logic [7:0] step_tmr   = '0;

    t_out_item   pending_res [$];
    int unsigned sent_cnt   = 0;
    int unsigned mismatches = 0;
    int unsigned stall_left = 0;
    logic        quiet      = 1'b0;

    // Directed opening: typed results where obvious, model elsewhere
    t_dir_row dir_tbl [DIR_ROWS] = '{
        '{ACT_STATUS_RD, 8'h00, 1'b0, 8'd1,   1'b1, '{BYTE_BLANK, MREQ_NONE, 4'd0, 19'd0, 8'h00}},
        '{ACT_TICK,      8'h00, 1'b0, 8'd1,   1'b1, ZERO_RES},
        '{ACT_UNUSED,    8'hff, 1'b1, 8'd1,   1'b1, ZERO_RES},
        '{ACT_DATA_RD,   8'h00, 1'b0, 8'd1,   1'b1, '{8'h00, MREQ_READ, 4'd0, 19'd0, 8'h00}},
        '{ACT_DATA_WR,   8'hff, 1'b0, 8'd1,   1'b1, '{8'h00, MREQ_WRITE, 4'd0, 19'd1, 8'hff}},
        '{ACT_SELECT,    8'h0f, 1'b0, 8'd1,   1'b1, ZERO_RES},
        '{ACT_STATUS_RD, 8'h00, 1'b1, 8'd1,   1'b1, '{8'h85, MREQ_NONE, 4'd0, 19'd0, 8'h00}},
        '{ACT_STATUS_RD, 8'h00, 1'b0, 8'd1,   1'b1, '{STATUS_SELECTED, MREQ_NONE, 4'd0, 19'd0, 8'h00}},
        '{ACT_CONTROL,   8'hff, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_CONTROL,   8'h01, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_SECTOR_RD, 8'h00, 1'b0, 8'd1,   1'b1, '{BYTE_BLANK, MREQ_NONE, 4'd0, 19'd0, 8'h00}},
        '{ACT_CONTROL,   8'h04, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_TICK,      8'h00, 1'b0, 8'd41,  1'b0, ZERO_RES},
        '{ACT_SECTOR_RD, 8'h00, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_SECTOR_RD, 8'h00, 1'b1, 8'd1,   1'b0, ZERO_RES},
        '{ACT_DATA_RD,   8'h00, 1'b0, 8'd140, 1'b0, ZERO_RES},
        '{ACT_CONTROL,   8'h80, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_DATA_WR,   8'h5a, 1'b1, 8'd140, 1'b0, ZERO_RES},
        '{ACT_CONTROL,   8'h02, 1'b0, 8'd3,   1'b0, ZERO_RES},
        '{ACT_CONTROL,   8'h01, 1'b0, 8'd80,  1'b0, ZERO_RES},
        '{ACT_STATUS_RD, 8'h00, 1'b1, 8'd1,   1'b0, ZERO_RES},
        '{ACT_TICK,      8'h00, 1'b0, 8'd44,  1'b0, ZERO_RES},
        '{ACT_SECTOR_RD, 8'h00, 1'b0, 8'd1,   1'b0, ZERO_RES},
        '{ACT_SELECT,    8'h0e, 1'b0, 8'd1,   1'b1, ZERO_RES},
        '{ACT_STATUS_RD, 8'h00, 1'b1, 8'd1,   1'b1, '{STATUS_IDLE, MREQ_NONE, 4'd0, 19'd0, 8'h00}},
        '{ACT_DATA_RD,   8'h00, 1'b0, 8'd3,   1'b0, ZERO_RES},
        '{ACT_DATA_WR,   8'h33, 1'b0, 8'd2,   1'b0, ZERO_RES},
        '{ACT_SELECT,    8'h80, 1'b0, 8'd1,   1'b1, ZERO_RES}
    };

    floppy_disk_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Model helpers
    function automatic logic drive_mounted(input logic [3:0] d);
        return (int'(d) < DRIVE_COUNT) && cfg_m.drive_present_mask[d];
    endfunction

    function automatic logic [ADDR_W-1:0] img_offset(input logic [6:0] trk,
                                                     input logic [4:0] sec,
                                                     input logic [7:0] idx);
        int unsigned o;
        o = (int'(trk) * SECTORS_PER_TRACK + int'(sec)) * SECTOR_BYTES + int'(idx);
        return o[ADDR_W-1:0];
    endfunction

    function automatic void park_controller();
        ctl_en    = 1'b0;
        sts       = STATUS_IDLE;
        hd_loaded = 1'b0;
        wr_active = 1'b0;
        hd_tmr    = '0;
        step_tmr  = '0;
    endfunction

    function automatic void head_stepped();
        sts[ST_MOVEHD] = 1'b1;
        step_tmr       = cfg_m.step_ticks;
        if (hd_loaded) begin
            sts[ST_STATHD] = 1'b1;
            hd_tmr         = cfg_m.load_ticks;
        end
    endfunction

    function automatic void tick_advance();
        int c;
        if (!ctl_en) return;
        c = int'(tick_cnt) + 1;
        if (c > int'(cfg_m.sector_ticks)) begin
            tick_cnt = '0;
            if (int'(sec_pos) + 1 >= SECTORS_PER_TRACK) sec_pos = '0;
            else sec_pos = sec_pos + 1'b1;
        end else begin
            tick_cnt = 8'(c);
        end
        if (hd_tmr != 0) begin
            hd_tmr = hd_tmr - 1'b1;
            if (hd_tmr == 0) sts[ST_STATHD] = 1'b0;
        end
        if (step_tmr != 0) begin
            step_tmr = step_tmr - 1'b1;
            if (step_tmr == 0) sts[ST_MOVEHD] = 1'b0;
        end
    endfunction

    // Advance the model by one transaction and return its result
    function automatic t_out_item fdc_predict(input t_in_item it);
        t_out_item  r;
        logic [3:0] drv;
        logic [7:0] d;
        logic       here;
        logic       same;
        r    = '0;
        drv  = sel_drv;
        d    = it.data_byte;
        case (it.action)
            ACT_TICK: begin
                tick_advance();
            end
            ACT_SELECT: begin
                if ((d & SEL_OFF) != 0) begin
                    park_controller();
                end else begin
                    sel_drv = d[3:0];
                    if (!drive_mounted(sel_drv)) begin
                        park_controller();
                    end else begin
                        ctl_en    = 1'b1;
                        sts       = STATUS_SELECTED;
                        wr_active = 1'b0;
                        hd_loaded = 1'b0;
                        hd_tmr    = '0;
                        step_tmr  = '0;
                    end
                end
            end
            ACT_STATUS_RD: begin
                if (ctl_en) begin
                    sts[ST_INTE]   = !it.cpu_int_enabled;
                    sts[ST_TRACK0] = (trk_tab[drv] != 0);
                end
                r.read_data = sts;
            end
            ACT_CONTROL: begin
                if (ctl_en) begin
                    if ((d & CTL_STEP_IN) != 0 && int'(trk_tab[drv]) + 1 < TRACK_COUNT) begin
                        trk_tab[drv] = trk_tab[drv] + 1'b1;
                        head_stepped();
                    end
                    if ((d & CTL_STEP_OUT) != 0 && trk_tab[drv] != 0) begin
                        trk_tab[drv] = trk_tab[drv] - 1'b1;
                        head_stepped();
                    end
                    if ((d & CTL_HEAD_LOAD) != 0) begin
                        hd_loaded      = 1'b1;
                        hd_tmr         = cfg_m.load_ticks;
                        sts[ST_MOVEHD] = 1'b1;
                        step_tmr       = cfg_m.load_ticks;
                    end
                    if ((d & CTL_HEAD_UNLOAD) != 0) begin
                        hd_loaded      = 1'b0;
                        hd_tmr         = '0;
                        sts[ST_STATHD] = 1'b1;
                    end
                    if ((d & CTL_WRITE_EN) != 0 && !wr_active) begin
                        wr_active    = 1'b1;
                        byte_cnt     = '0;
                        sts[ST_ENWD] = 1'b0;
                    end
                end
            end
            ACT_SECTOR_RD: begin
                if (!ctl_en || sts[ST_STATHD]) begin
                    sts[ST_NRDA] = 1'b1;
                    sts[ST_ENWD] = 1'b1;
                    r.read_data  = BYTE_BLANK;
                end else begin
                    same = 1'b1;
                    if (sec_pos != rw_sec) begin
                        rw_sec       = sec_pos;
                        same         = 1'b0;
                        sts[ST_NRDA] = 1'b0;
                        sts[ST_ENWD] = 1'b1;
                        byte_cnt     = '0;
                    end
                    r.read_data = {2'b00, rw_sec, same};
                end
            end
            ACT_DATA_WR: begin
                if (byte_cnt < SECTOR_BYTES) begin
                    here = drive_mounted(drv);
                    if (here) begin
                        r.mem_request    = MREQ_WRITE;
                        r.mem_drive      = drv;
                        r.mem_address    = img_offset(trk_tab[drv], rw_sec, byte_cnt);
                        r.mem_write_data = d;
                    end
                    byte_cnt = byte_cnt + 1'b1;
                    if (byte_cnt == SECTOR_BYTES) begin
                        wr_active = 1'b0;
                        if (!here) park_controller();
                    end
                end
            end
            ACT_DATA_RD: begin
                if (byte_cnt == 0) begin
                    if (!drive_mounted(drv)) begin
                        park_controller();
                        blank_rd = 1'b1;
                    end else begin
                        blank_rd = 1'b0;
                        rd_trk   = trk_tab[drv];
                    end
                end
                if (byte_cnt >= SECTOR_BYTES) begin
                    r.read_data = BYTE_BLANK;
                end else begin
                    if (blank_rd) begin
                        r.read_data = BYTE_BLANK;
                    end else begin
                        r.mem_request = MREQ_READ;
                        r.mem_drive   = drv;
                        r.mem_address = img_offset(rd_trk, rw_sec, byte_cnt);
                    end
                    byte_cnt = byte_cnt + 1'b1;
                    if (byte_cnt == SECTOR_BYTES) sts[ST_NRDA] = 1'b1;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Gap length shared by both sides: mostly none, some short, a few long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [3:0] pick_drive();
        logic [3:0] d;
        d = 4'($urandom_range(0, 15));
        if (cfg_m.drive_present_mask == 0 || $urandom_range(0, 4) == 0) return d;
        while (!cfg_m.drive_present_mask[d]) d = d + 1'b1;
        return d;
    endfunction

    // Drive one transaction, wait for acceptance, queue its result
    task automatic send_txn(input logic [2:0] act, input logic [7:0] dat, input logic ie,
                            input logic typed, input t_out_item res);
        int unsigned gap;
        t_in_item    it;
        t_out_item   p;
        it.action          = act;
        it.data_byte       = dat;
        it.cpu_int_enabled = ie;
        gap = idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        p = fdc_predict(it);
        pending_res.push_back(typed ? res : p);
        sent_cnt = sent_cnt + 1;
        if ($urandom_range(0, 199) == 0) quiet = !quiet;
    endtask

    task automatic send(input logic [2:0] act, input logic [7:0] dat, input logic ie);
        send_txn(act, dat, ie, 1'b0, ZERO_RES);
    endtask

    // Drop valid and wait until every result is back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DRIVE_MASK:   cfg_m.drive_present_mask = val;
            CFG_STEP_TICKS:   cfg_m.step_ticks         = val[7:0];
            CFG_LOAD_TICKS:   cfg_m.load_ticks         = val[7:0];
            CFG_SECTOR_TICKS: cfg_m.sector_ticks       = val[7:0];
            default: ;
        endcase
    endtask

    // Select, load, settle, locate a sector, then burst data through it
    task automatic sector_run(input logic wr);
        int unsigned n;
        int unsigned k;
        send(ACT_SELECT, {1'b0, 3'($urandom), pick_drive()}, 1'($urandom));
        repeat ($urandom_range(0, 3))
            send(ACT_CONTROL, $urandom_range(0, 1) ? CTL_STEP_IN : CTL_STEP_OUT, 1'($urandom));
        send(ACT_CONTROL, CTL_HEAD_LOAD | (wr ? CTL_WRITE_EN : 8'h00), 1'($urandom));
        k = 0;
        while (ctl_en && sts[ST_STATHD] && k < SETTLE_CAP) begin
            send(ACT_TICK, 8'($urandom), 1'($urandom));
            k++;
        end
        repeat ($urandom_range(0, 12)) send(ACT_TICK, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 3) == 0) send(ACT_STATUS_RD, 8'($urandom), 1'($urandom));
        send(ACT_SECTOR_RD, 8'($urandom), 1'($urandom));
        n = ($urandom_range(0, 4) != 0) ? SECTOR_BYTES : $urandom_range(1, SECTOR_BYTES + 3);
        repeat (n) send(wr ? ACT_DATA_WR : ACT_DATA_RD, 8'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 0) send(ACT_STATUS_RD, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned first;
        int unsigned r;
        first = sent_cnt;
        while (sent_cnt - first < budget) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                sector_run(1'b0);
            end else if (r < 65) begin
                sector_run(1'b1);
            end else if (r < 75) begin
                repeat ($urandom_range(1, 6))
                    send(ACT_CONTROL, 8'($urandom_range(0, 15)) | (8'($urandom) & CTL_WRITE_EN),
                         1'($urandom));
            end else begin
                repeat ($urandom_range(1, 8))
                    send(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic cmp_field(input string fld, input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, fld, want, got);
        end
    endtask

    // Check each result transaction and pick the next output stall
    always @(posedge i_clk) begin
        t_out_item   want;
        int unsigned len;
        logic        stall_nxt;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual 0x%0h", $time, o_out_data);
            end else begin
                want = pending_res.pop_front();
                cmp_field("read_data",      want.read_data,      o_out_data.read_data);
                cmp_field("mem_request",    want.mem_request,    o_out_data.mem_request);
                cmp_field("mem_drive",      want.mem_drive,      o_out_data.mem_drive);
                cmp_field("mem_address",    want.mem_address,    o_out_data.mem_address);
                cmp_field("mem_write_data", want.mem_write_data, o_out_data.mem_write_data);
            end
        end
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            stall_nxt  = 1'b1;
        end else begin
            len       = idle_len();
            stall_nxt = (len != 0);
            if (len != 0) stall_left = len - 1;
        end
        i_out_stall <= stall_nxt;
    end

    // Main sequence
    initial begin
        t_dir_row row;
        t_cfg     pc;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drive 14 has no image for the directed part; other registers keep reset values
        write_reg(CFG_DRIVE_MASK, 16'hbfff);
        for (int i = 0; i < DIR_ROWS; i++) begin
            row = dir_tbl[i];
            repeat (row.reps) send_txn(row.act, row.dat, row.ie, row.typed, row.res);
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: pc = '{16'hffff, 8'd1, 8'd1, 8'd1};
                1: pc = '{16'($urandom_range(1, 16'hfffe)), 8'd255, 8'd255, 8'd255};
                2: pc = '{16'h0000, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          8'($urandom_range(1, 255))};
                3: pc = '{16'($urandom_range(1, 16'hfffe)), 8'($urandom_range(1, 20)),
                          8'($urandom_range(1, 20)), 8'($urandom_range(1, 20))};
                default: pc = '{16'hffff, 8'($urandom_range(1, 255)),
                                8'($urandom_range(1, 60)), 8'($urandom_range(1, 255))};
            endcase
            write_reg(CFG_DRIVE_MASK,   pc.drive_present_mask);
            write_reg(CFG_STEP_TICKS,   {8'h00, pc.step_ticks});
            write_reg(CFG_LOAD_TICKS,   {8'h00, pc.load_ticks});
            write_reg(CFG_SECTOR_TICKS, {8'h00, pc.sector_ticks});
            run_random(PHASE_ITEMS);
        end

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop for a hung handshake
    initial begin
        #(LIMIT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
